/* rtl/command_message_parser_defines.svh */
// Assertion macros shared by the parser modules.
// Users must have i_clk and i_rst_n in scope.
`ifndef COMMAND_MESSAGE_PARSER_DEFINES_SVH
`define COMMAND_MESSAGE_PARSER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define CMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequence checked in the cycle after the trigger.
`define CMP_ASSERT_NEXT(label, trig, cons, msg) \
    `CMP_ASSERT(label, (trig) |=> (cons), msg)

`endif

/* rtl/cmp_pkg.sv */
// Shared types, character constants and character classes of the command parser.
// No dependencies.
package cmp_pkg;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_BRACKET_OR_END,
        PH_END,
        PH_VALUE,
        PH_DIGIT,
        PH_DIGITS,
        PH_STRING,
        PH_COMMA_OR_BRACKET
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_OPCODE,
        ERR_UNEXPECTED,
        ERR_STRINGS,
        ERR_BAD_STRING,
        ERR_STRING_LONG,
        ERR_VECTOR_LONG,
        ERR_RANGE
    } t_err;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_TEXT   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } t_ctrl_state;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic step;
        logic load_status;
        logic emit_start;
        logic load_item;
    } t_ctrl_cmd;

    typedef struct packed {
        logic emit_needed;
        logic item_last;
    } t_dp_status;

    typedef struct packed {
        logic               done;
        t_err               err;
        logic [7:0]         opcode;
        logic [3:0]         value_count;
        logic               has_text;
        logic [5:0]         text_length;
        t_kind              kind;
        logic [4:0]         index;
        logic signed [15:0] value;
        logic               last;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    // Letters, digits, '?' and the punctuation allowed inside a quoted string.
    function automatic logic is_text_char(input logic [7:0] c);
        logic ok;
        case (c)
            8'h2D, 8'h5F, 8'h20, 8'h21, 8'h3F, 8'h25, 8'h28, 8'h29,
            8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h26, 8'h3D, 8'h2B, 8'h2A,
            8'h2F, 8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h27: ok = 1'b1;
            default: ok = is_alnum(c);
        endcase
        return ok;
    endfunction

endpackage

/* rtl/cmp_datapath.sv */
// Parser datapath: parse registers, argument and string stores, result register.
// Depends on cmp_pkg and command_message_parser_defines.svh.
`include "command_message_parser_defines.svh"

module cmp_datapath
    import cmp_pkg::*;
#(
    parameter int MAX_VALUES = 12,
    parameter int MAX_TEXT   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    input  logic [7:0] i_byte,
    input  logic       i_sop,
    output t_dp_status o_status,
    output t_result    o_result
);

    localparam int VCW = $clog2(MAX_VALUES + 1);
    localparam int TCW = $clog2(MAX_TEXT + 1);
    localparam int KW  = $clog2(MAX_VALUES + MAX_TEXT + 1);
    localparam int VAW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

    // Parser state.
    t_phase             r_phase,     n_phase;
    logic               r_halted,    n_halted;
    logic [7:0]         r_opcode,    n_opcode;
    logic [VCW-1:0]     r_vt,        n_vt;
    logic signed [15:0] r_partial,   n_partial;
    logic               r_neg,       n_neg;
    logic               r_text_seen, n_text_seen;
    logic [TCW-1:0]     r_tt,        n_tt;
    logic [KW-1:0]      r_k,         n_k;
    t_result            r_result,    n_result;

    logic signed [15:0] r_val_mem [MAX_VALUES];
    logic [7:0]         r_txt_mem [MAX_TEXT];
    logic signed [15:0] r_val_rd;
    logic [7:0]         r_txt_rd;

    // Effective state after an optional start-of-message clear.
    t_phase             e_phase;
    logic               e_halted;
    logic [7:0]         e_opcode;
    logic [VCW-1:0]     e_vt;
    logic signed [15:0] e_partial;
    logic               e_neg;
    logic               e_text_seen;
    logic [TCW-1:0]     e_tt;

    t_err               h_err;
    logic               h_done;
    logic               val_we;
    logic               txt_we;
    logic [3:0]         digit_val;
    logic signed [20:0] times_ten;
    logic signed [20:0] next_val;

    logic [KW-1:0]      total;
    logic [KW-1:0]      txt_idx;
    logic [KW-1:0]      item_idx;
    logic               in_values;
    logic [KW+4:0]      item_idx_ext;
    logic [VCW+3:0]     n_vt_ext;
    logic [TCW+5:0]     n_tt_ext;
    logic [VCW+3:0]     r_vt_ext;
    logic [TCW+5:0]     r_tt_ext;

    assign e_phase     = i_sop ? PH_OPCODE : r_phase;
    assign e_halted    = i_sop ? 1'b0 : r_halted;
    assign e_opcode    = i_sop ? 8'd0 : r_opcode;
    assign e_vt        = i_sop ? '0 : r_vt;
    assign e_partial   = i_sop ? 16'sd0 : r_partial;
    assign e_neg       = i_sop ? 1'b0 : r_neg;
    assign e_text_seen = i_sop ? 1'b0 : r_text_seen;
    assign e_tt        = i_sop ? '0 : r_tt;

    assign digit_val = i_byte[3:0] - CH_ZERO[3:0];
    assign times_ten = (21'(e_partial) <<< 3) + (21'(e_partial) <<< 1);
    assign next_val  = e_neg ? (times_ten - 21'(digit_val)) : (times_ten + 21'(digit_val));

    // One byte through the grammar.
    always_comb begin
        n_phase     = e_phase;
        n_halted    = e_halted;
        n_opcode    = e_opcode;
        n_vt        = e_vt;
        n_partial   = e_partial;
        n_neg       = e_neg;
        n_text_seen = e_text_seen;
        n_tt        = e_tt;
        h_err       = ERR_NONE;
        h_done      = 1'b0;
        val_we      = 1'b0;
        txt_we      = 1'b0;
        case (e_phase)
            PH_OPCODE: begin
                if (is_alnum(i_byte) || i_byte == CH_QMARK) begin
                    n_opcode = i_byte;
                    n_phase  = PH_BRACKET_OR_END;
                end else begin
                    h_err = ERR_OPCODE;
                end
            end
            PH_BRACKET_OR_END: begin
                if (i_byte == CH_OPEN) begin
                    n_phase = PH_VALUE;
                end else if (i_byte == CH_NUL) begin
                    h_done = 1'b1;
                end else begin
                    h_err = ERR_UNEXPECTED;
                end
            end
            PH_END: begin
                if (i_byte == CH_NUL) begin
                    n_phase = PH_OPCODE;
                    h_done  = 1'b1;
                end else begin
                    h_err = ERR_UNEXPECTED;
                end
            end
            PH_VALUE: begin
                if (i_byte == CH_MINUS) begin
                    n_partial = 16'sd0;
                    n_neg     = 1'b1;
                    n_phase   = PH_DIGIT;
                end else if (is_digit(i_byte)) begin
                    n_partial = 16'(digit_val);
                    n_neg     = 1'b0;
                    n_phase   = PH_DIGITS;
                end else if (i_byte == CH_QUOTE) begin
                    if (e_text_seen) begin
                        h_err = ERR_STRINGS;
                    end else begin
                        n_phase = PH_STRING;
                    end
                end else begin
                    h_err = ERR_UNEXPECTED;
                end
            end
            PH_DIGIT, PH_DIGITS: begin
                if (is_digit(i_byte)) begin
                    if (next_val > 21'sd32767 || next_val < -21'sd32768) begin
                        h_err = ERR_RANGE;
                    end else begin
                        n_partial = next_val[15:0];
                        n_phase   = PH_DIGITS;
                    end
                end else if (e_phase == PH_DIGITS
                             && (i_byte == CH_COMMA || i_byte == CH_CLOSE)) begin
                    if (e_vt >= VCW'(MAX_VALUES)) begin
                        h_err = ERR_VECTOR_LONG;
                    end else begin
                        val_we  = 1'b1;
                        n_vt    = e_vt + VCW'(1);
                        n_phase = (i_byte == CH_COMMA) ? PH_VALUE : PH_END;
                    end
                end else begin
                    h_err = ERR_UNEXPECTED;
                end
            end
            PH_STRING: begin
                if (i_byte == CH_QUOTE) begin
                    n_text_seen = 1'b1;
                    n_phase     = PH_COMMA_OR_BRACKET;
                end else if (i_byte == CH_NUL || !is_text_char(i_byte)) begin
                    h_err = ERR_BAD_STRING;
                end else if (e_tt >= TCW'(MAX_TEXT)) begin
                    h_err = ERR_STRING_LONG;
                end else begin
                    txt_we = 1'b1;
                    n_tt   = e_tt + TCW'(1);
                end
            end
            PH_COMMA_OR_BRACKET: begin
                if (i_byte == CH_COMMA) begin
                    n_phase = PH_VALUE;
                end else if (i_byte == CH_CLOSE) begin
                    n_phase = PH_END;
                end else begin
                    h_err = ERR_UNEXPECTED;
                end
            end
            default: begin
                h_err = ERR_UNEXPECTED;
            end
        endcase

        // A halted parser ignores the byte; an error leaves everything but
        // the phase and the halt flag as they were.
        if (e_halted || h_err != ERR_NONE) begin
            n_phase     = e_halted ? e_phase : PH_OPCODE;
            n_halted    = 1'b1;
            n_opcode    = e_opcode;
            n_vt        = e_vt;
            n_partial   = e_partial;
            n_neg       = e_neg;
            n_text_seen = e_text_seen;
            n_tt        = e_tt;
            h_done      = 1'b0;
            val_we      = 1'b0;
            txt_we      = 1'b0;
            if (e_halted) begin
                h_err = ERR_NONE;
            end
        end
    end

    // Emission walks one index over the arguments and then the characters.
    assign total     = KW'(r_vt) + KW'(r_tt);
    assign in_values = r_k < KW'(r_vt);
    assign txt_idx   = r_k - KW'(r_vt);
    assign item_idx  = in_values ? r_k : txt_idx;

    assign item_idx_ext = {5'd0, item_idx};
    assign n_vt_ext     = {4'd0, n_vt};
    assign n_tt_ext     = {6'd0, n_tt};
    assign r_vt_ext     = {4'd0, r_vt};
    assign r_tt_ext     = {6'd0, r_tt};

    assign o_status.emit_needed = h_done && ((n_vt != '0) || (n_tt != '0));
    assign o_status.item_last   = (r_k + KW'(1)) == total;

    always_comb begin
        n_k      = r_k;
        n_result = r_result;
        if (i_cmd.emit_start) begin
            n_k = '0;
        end else if (i_cmd.load_item) begin
            n_k = r_k + KW'(1);
        end
        if (i_cmd.load_status) begin
            n_result.done        = h_done;
            n_result.err         = h_err;
            n_result.opcode      = n_opcode;
            n_result.value_count = n_vt_ext[3:0];
            n_result.has_text    = n_text_seen;
            n_result.text_length = n_tt_ext[5:0];
            n_result.kind        = KIND_STATUS;
            n_result.index       = 5'd0;
            n_result.value       = 16'sd0;
            n_result.last        = 1'b1;
        end else if (i_cmd.load_item) begin
            n_result.done        = 1'b1;
            n_result.err         = ERR_NONE;
            n_result.opcode      = r_opcode;
            n_result.value_count = r_vt_ext[3:0];
            n_result.has_text    = r_text_seen;
            n_result.text_length = r_tt_ext[5:0];
            n_result.kind        = in_values ? KIND_VALUE : KIND_TEXT;
            n_result.index       = item_idx_ext[4:0];
            n_result.value       = in_values ? r_val_rd : {8'd0, r_txt_rd};
            n_result.last        = o_status.item_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPCODE;
            r_halted    <= 1'b0;
            r_opcode    <= 8'd0;
            r_vt        <= '0;
            r_partial   <= 16'sd0;
            r_neg       <= 1'b0;
            r_text_seen <= 1'b0;
            r_tt        <= '0;
            r_k         <= '0;
        end else begin
            if (i_cmd.step) begin
                r_phase     <= n_phase;
                r_halted    <= n_halted;
                r_opcode    <= n_opcode;
                r_vt        <= n_vt;
                r_partial   <= n_partial;
                r_neg       <= n_neg;
                r_text_seen <= n_text_seen;
                r_tt        <= n_tt;
            end
            r_k <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // Argument and string stores: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && val_we) begin
            r_val_mem[e_vt[VAW-1:0]] <= e_partial;
        end
        r_val_rd <= r_val_mem[r_k[VAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && txt_we) begin
            r_txt_mem[e_tt[TAW-1:0]] <= i_byte;
        end
        r_txt_rd <= r_txt_mem[txt_idx[TAW-1:0]];
    end

    assign o_result = r_result;

    `CMP_ASSERT(a_halt_phase, r_halted |-> (r_phase == PH_OPCODE), "halted parser not at opcode")
    `CMP_ASSERT(a_count_bound, (r_vt <= VCW'(MAX_VALUES)) && (r_tt <= TCW'(MAX_TEXT)), "store count overflow")
    `CMP_ASSERT_NEXT(a_store_grow, i_cmd.step && val_we, r_vt == $past(e_vt) + VCW'(1), "argument count did not advance")

endmodule

/* rtl/cmp_ctrl.sv */
// Parser controller: accepts bytes, sequences the emission of a completed request
// and owns the result valid flag. Depends on cmp_pkg and the assertion macros.
`include "command_message_parser_defines.svh"

module cmp_ctrl
    import cmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = out_free;
                if (i_s_tvalid && out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.emit_needed) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = ST_FETCH;
                    end else begin
                        o_cmd.load_status = 1'b1;
                        n_out_valid       = 1'b1;
                    end
                end
            end
            // The store read address settles here; data is registered for ST_SEND.
            ST_FETCH: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    o_cmd.load_item = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = i_status.item_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;

    `CMP_ASSERT_NEXT(a_emit_fetch, o_cmd.step && i_status.emit_needed, r_state == ST_FETCH, "completed request did not start emission")
    `CMP_ASSERT_NEXT(a_last_idle, (r_state == ST_SEND) && out_free && i_status.item_last, r_state == ST_IDLE, "emission ran past last item")
    `CMP_ASSERT_NEXT(a_load_valid, o_cmd.load_status || o_cmd.load_item, r_out_valid, "loaded result not presented")

endmodule

/* rtl/command_message_parser.sv */
// Latency: a byte's status result is presented the cycle after the byte is accepted.
// Throughput: one byte per cycle while results are taken; a byte that completes a
// request with N arguments and characters emits N results, each by a store read and
// then the result register, and holds input off until the last one is loaded.
// Reset (synchronous, active low) clears the parser state and the result valid flag;
// the argument and string stores are not cleared.
module command_message_parser
    import cmp_pkg::*;
#(
    parameter int MAX_VALUES = 12,
    parameter int MAX_TEXT   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // in_byte
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // start_of_message
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // request_done, error_code, opcode, value_count, has_text, text_length,
    // item_index, item_value, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser,  // item_kind
    output logic                 m_axis_tlast   // last
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_result    result;

    cmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cmp_datapath #(
        .MAX_VALUES (MAX_VALUES),
        .MAX_TEXT   (MAX_TEXT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (s_axis_tdata[7:0]),
        .i_sop    (s_axis_tuser[0]),
        .o_status (status),
        .o_result (result)
    );

    assign m_axis_tdata = {4'd0, result.value, result.index, result.text_length,
                           result.has_text, result.value_count, result.opcode,
                           result.err, result.done};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

/* verif/command_message_parser_tb.sv */
// Self-checking testbench for command_message_parser: a short table of directed bytes, then
// random well-formed, broken and noisy messages, all checked against a parser model kept here.
// Depends on cmp_pkg and the command_message_parser RTL.
module command_message_parser_tb
    import cmp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARG_MAX      = 12;
    localparam int TEXT_MAX     = 32;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_BYTES  = 70;
    localparam int MAX_PRINTED  = 30;

    // Sender and receiver idle percentages, one pair per phase.
    localparam int SRC_IDLE [3] = '{28, 88, 0};
    localparam int DST_IDLE [3] = '{88, 28, 0};

    typedef enum int {
        SC_GOOD,
        SC_RANGE,
        SC_MANY_ARGS,
        SC_LONG_TEXT,
        SC_TWO_TEXTS,
        SC_BAD_TEXT,
        SC_MUTATED,
        SC_NOISE,
        SC_BAD_OPCODE
    } t_scenario;

    typedef struct packed {
        logic       som;
        logic [7:0] ch;
    } t_in_byte;

    typedef struct packed {
        logic       som;
        logic [7:0] ch;
        logic       chk;
        logic       done;
        t_err       err;
    } t_row;

    // Directed bytes; done and error are typed in only where they are obvious.
    localparam t_row PLAN [25] = '{
        '{1'b1, CH_QMARK, 1'b1, 1'b0, ERR_NONE},        // first byte after reset
        '{1'b0, CH_NUL,   1'b1, 1'b1, ERR_NONE},        // bare opcode completes
        '{1'b0, CH_NUL,   1'b1, 1'b1, ERR_NONE},        // and completes again
        '{1'b1, 8'h7A,    1'b0, 1'b0, ERR_NONE},        // 'z'
        '{1'b0, CH_OPEN,  1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_MINUS, 1'b0, 1'b0, ERR_NONE},
        '{1'b0, 8'h33,    1'b0, 1'b0, ERR_NONE},        // -32768, the lowest value
        '{1'b0, 8'h32,    1'b0, 1'b0, ERR_NONE},
        '{1'b0, 8'h37,    1'b0, 1'b0, ERR_NONE},
        '{1'b0, 8'h36,    1'b0, 1'b0, ERR_NONE},
        '{1'b0, 8'h38,    1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_COMMA, 1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_QUOTE, 1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_QMARK, 1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_QUOTE, 1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_CLOSE, 1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_NUL,   1'b1, 1'b1, ERR_NONE},
        '{1'b1, 8'hFF,    1'b1, 1'b0, ERR_OPCODE},
        '{1'b0, CH_NUL,   1'b1, 1'b0, ERR_NONE},        // ignored while halted
        '{1'b1, 8'h41,    1'b0, 1'b0, ERR_NONE},        // 'A'
        '{1'b0, CH_OPEN,  1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_MINUS, 1'b0, 1'b0, ERR_NONE},
        '{1'b0, CH_CLOSE, 1'b1, 1'b0, ERR_UNEXPECTED},  // minus sign with no digit
        '{1'b1, 8'h39,    1'b0, 1'b0, ERR_NONE},        // '9'
        '{1'b0, 8'h78,    1'b1, 1'b0, ERR_UNEXPECTED}   // 'x'
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // in_byte
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // start_of_message
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // request_done, error_code, opcode, value_count, has_text, text_length,
    // item_index, item_value, zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;        // item_kind
    logic                 m_axis_tlast;

    // Typed expectation of the current table row, driven alongside the byte.
    logic                 row_chk  = 1'b0;
    logic                 row_done = 1'b0;
    t_err                 row_err  = ERR_NONE;

    int src_idle = SRC_IDLE[0];
    int dst_idle = DST_IDLE[0];

    int       mismatches    = 0;
    int       results_seen  = 0;
    int       bytes_in      = 0;
    int       live_bytes    = 0;
    int       requests_done = 0;
    int       stall_cycles  = 0;
    bit [7:0] codes_hit     = '0;

    t_result  want_q [$];
    t_in_byte msg_q [$];

    string text_marks = "-_ !?%()[]{}&=+*/.,;:'";

    // Parser state as the block should hold it.
    t_phase             ph;
    bit                 halted;
    logic [7:0]         held_op;
    logic signed [15:0] arg_store [ARG_MAX];
    int                 arg_total;
    int                 run_value;
    bit                 run_neg;
    bit                 text_done;
    logic [7:0]         char_store [TEXT_MAX];
    int                 char_total;

    command_message_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= CH_ZERO && c <= CH_NINE) || (c == CH_QMARK);
    endfunction

    function automatic bit is_text_ok(input logic [7:0] c);
        bit ok;
        ok = is_word_char(c);
        for (int i = 0; i < text_marks.len(); i++) begin
            if (text_marks[i] == c) ok = 1'b1;
        end
        return ok;
    endfunction

    function automatic void clear_parser();
        ph         = PH_OPCODE;
        halted     = 1'b0;
        held_op    = '0;
        arg_total  = 0;
        run_value  = 0;
        run_neg    = 1'b0;
        text_done  = 1'b0;
        char_total = 0;
    endfunction

    function automatic t_result make_result(input logic dn, input t_err er, input t_kind kd,
                                            input int idx, input logic [15:0] val,
                                            input logic lst);
        t_result r;
        r.done        = dn;
        r.err         = er;
        r.opcode      = held_op;
        r.value_count = 4'(arg_total);
        r.has_text    = text_done;
        r.text_length = 6'(char_total);
        r.kind        = kd;
        r.index       = 5'(idx);
        r.value       = val;
        r.last        = lst;
        return r;
    endfunction

    // Advances the grammar by one character and returns the error it raises.
    function automatic t_err parse_char(input logic [7:0] c, output bit dn);
        bit digit;
        int d;
        int nxt;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d     = int'(c) - int'(CH_ZERO);
        dn    = 1'b0;
        case (ph)
            PH_OPCODE: begin
                if (!is_word_char(c)) return ERR_OPCODE;
                held_op = c;
                ph      = PH_BRACKET_OR_END;
                return ERR_NONE;
            end
            PH_BRACKET_OR_END: begin
                if (c == CH_OPEN) begin
                    ph = PH_VALUE;
                    return ERR_NONE;
                end
                if (c == CH_NUL) begin
                    dn = 1'b1;
                    return ERR_NONE;
                end
                return ERR_UNEXPECTED;
            end
            PH_END: begin
                if (c != CH_NUL) return ERR_UNEXPECTED;
                ph = PH_OPCODE;
                dn = 1'b1;
                return ERR_NONE;
            end
            PH_VALUE: begin
                if (c == CH_MINUS) begin
                    run_value = 0;
                    run_neg   = 1'b1;
                    ph        = PH_DIGIT;
                    return ERR_NONE;
                end
                if (digit) begin
                    run_value = d;
                    run_neg   = 1'b0;
                    ph        = PH_DIGITS;
                    return ERR_NONE;
                end
                if (c == CH_QUOTE) begin
                    if (text_done) return ERR_STRINGS;
                    ph = PH_STRING;
                    return ERR_NONE;
                end
                return ERR_UNEXPECTED;
            end
            PH_DIGIT, PH_DIGITS: begin
                if (digit) begin
                    nxt = 10 * run_value + (run_neg ? -d : d);
                    if (nxt > 32767 || nxt < -32768) return ERR_RANGE;
                    run_value = nxt;
                    ph        = PH_DIGITS;
                    return ERR_NONE;
                end
                if (ph == PH_DIGITS && (c == CH_COMMA || c == CH_CLOSE)) begin
                    if (arg_total >= ARG_MAX) return ERR_VECTOR_LONG;
                    arg_store[arg_total] = 16'(run_value);
                    arg_total++;
                    ph = (c == CH_COMMA) ? PH_VALUE : PH_END;
                    return ERR_NONE;
                end
                return ERR_UNEXPECTED;
            end
            PH_STRING: begin
                if (c == CH_QUOTE) begin
                    text_done = 1'b1;
                    ph        = PH_COMMA_OR_BRACKET;
                    return ERR_NONE;
                end
                if (c == CH_NUL || !is_text_ok(c)) return ERR_BAD_STRING;
                if (char_total >= TEXT_MAX) return ERR_STRING_LONG;
                char_store[char_total] = c;
                char_total++;
                return ERR_NONE;
            end
            default: begin
                if (c == CH_COMMA) begin
                    ph = PH_VALUE;
                    return ERR_NONE;
                end
                if (c == CH_CLOSE) begin
                    ph = PH_END;
                    return ERR_NONE;
                end
                return ERR_UNEXPECTED;
            end
        endcase
    endfunction

    // Queues the results one accepted byte should cause; returns 0 for a byte the
    // block ignores because it is halted.
    function automatic bit predict_byte(input logic [7:0] c, input logic som);
        t_err er;
        bit   dn;
        int   total;
        int   k;
        if (som) clear_parser();
        if (halted) begin
            want_q.push_back(make_result(1'b0, ERR_NONE, KIND_STATUS, 0, '0, 1'b1));
            return 1'b0;
        end
        er = parse_char(c, dn);
        total = arg_total + char_total;
        if (er != ERR_NONE) begin
            ph     = PH_OPCODE;
            halted = 1'b1;
            want_q.push_back(make_result(1'b0, er, KIND_STATUS, 0, '0, 1'b1));
        end else if (!dn) begin
            want_q.push_back(make_result(1'b0, ERR_NONE, KIND_STATUS, 0, '0, 1'b1));
        end else if (total == 0) begin
            want_q.push_back(make_result(1'b1, ERR_NONE, KIND_STATUS, 0, '0, 1'b1));
        end else begin
            k = 0;
            for (int i = 0; i < arg_total; i++) begin
                k++;
                want_q.push_back(make_result(1'b1, ERR_NONE, KIND_VALUE, i, arg_store[i],
                                             k == total));
            end
            for (int i = 0; i < char_total; i++) begin
                k++;
                want_q.push_back(make_result(1'b1, ERR_NONE, KIND_TEXT, i,
                                             {8'h00, char_store[i]}, k == total));
            end
        end
        return 1'b1;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int n, input int got, input int exp_v);
        if (got != exp_v)
            log_mismatch($sformatf("result %0d: %s is %0d, should be %0d", n, name, got, exp_v));
    endtask

    // Receiver: ready is redrawn every cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end

    always @(posedge i_clk) begin : tracker
        t_result seen;
        t_result want;
        int      first;
        bit      took;
        if (i_rst_n) begin
            took = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                took              = 1'b1;
                results_seen++;
                seen.done        = m_axis_tdata[0];
                seen.err         = t_err'(m_axis_tdata[3:1]);
                seen.opcode      = m_axis_tdata[11:4];
                seen.value_count = m_axis_tdata[15:12];
                seen.has_text    = m_axis_tdata[16];
                seen.text_length = m_axis_tdata[22:17];
                seen.index       = m_axis_tdata[27:23];
                seen.value       = m_axis_tdata[43:28];
                seen.kind        = t_kind'(m_axis_tuser);
                seen.last        = m_axis_tlast;
                if (want_q.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing expected",
                                           results_seen));
                end else begin
                    want = want_q.pop_front();
                    check_field("request_done", results_seen, seen.done, want.done);
                    check_field("error_code", results_seen, seen.err, want.err);
                    check_field("opcode", results_seen, seen.opcode, want.opcode);
                    check_field("value_count", results_seen, seen.value_count,
                                want.value_count);
                    check_field("has_text", results_seen, seen.has_text, want.has_text);
                    check_field("text_length", results_seen, seen.text_length,
                                want.text_length);
                    check_field("item_kind", results_seen, seen.kind, want.kind);
                    check_field("item_index", results_seen, seen.index, want.index);
                    check_field("item_value", results_seen, seen.value, want.value);
                    check_field("last", results_seen, seen.last, want.last);
                    codes_hit[want.err] = 1'b1;
                    if (want.done && want.last) requests_done++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                took  = 1'b1;
                bytes_in++;
                first = want_q.size();
                if (predict_byte(s_axis_tdata, s_axis_tuser[0])) live_bytes++;
                if (row_chk && (want_q[first].done !== row_done ||
                                want_q[first].err !== row_err))
                    log_mismatch($sformatf("table byte %0d: model gives done %0d error %0d",
                                           bytes_in, want_q[first].done, want_q[first].err));
            end
            stall_cycles = took ? 0 : stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("Watchdog: no request moved for %0d cycles.", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] any_word_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'(8'h61 + r);
        if (r < 52) return 8'(8'h41 + r - 26);
        if (r < 62) return 8'(CH_ZERO + r - 52);
        return CH_QMARK;
    endfunction

    function automatic void push_byte(input logic [7:0] c, input logic som);
        t_in_byte b;
        b.som = som;
        b.ch  = c;
        msg_q.push_back(b);
    endfunction

    function automatic void push_value(input int v);
        string digits;
        if (v < 0) begin
            push_byte(CH_MINUS, 1'b0);
            v = -v;
        end
        if ($urandom_range(7) == 0) push_byte(CH_ZERO, 1'b0);
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) push_byte(digits[i], 1'b0);
    endfunction

    // A quoted string; a broken one carries one invalid character somewhere.
    function automatic void push_text(input int len, input bit broken);
        int         bad_at;
        logic [7:0] c;
        bad_at = broken ? int'($urandom_range(len)) : -1;
        push_byte(CH_QUOTE, 1'b0);
        for (int i = 0; i <= len; i++) begin
            if (i == bad_at) begin
                if ($urandom_range(3) == 0) begin
                    c = CH_NUL;
                end else begin
                    do c = 8'($urandom_range(255)); while (is_text_ok(c));
                end
                push_byte(c, 1'b0);
            end
            if (i < len) begin
                if ($urandom_range(3) == 0)
                    c = text_marks[$urandom_range(text_marks.len() - 1)];
                else
                    c = any_word_char();
                push_byte(c, 1'b0);
            end
        end
        push_byte(CH_QUOTE, 1'b0);
    endfunction

    function automatic void build_message(input t_scenario sc, input logic som);
        int         n_args;
        int         n_chars;
        int         text_at;
        int         bad_at;
        int         pick;
        int         v;
        bit         with_text;
        bit         first_elem;
        logic [7:0] c;
        t_in_byte   b;
        msg_q.delete();
        if (sc == SC_NOISE) begin
            repeat ($urandom_range(6, 1))
                push_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
        end else if (sc == SC_BAD_OPCODE) begin
            do c = 8'($urandom_range(255)); while (is_word_char(c));
            push_byte(c, som);
            repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0);
        end else begin
            push_byte(any_word_char(), som);
            pick = $urandom_range(9);
            if (sc == SC_MANY_ARGS)  n_args = ARG_MAX + 1;
            else if (sc == SC_RANGE) n_args = $urandom_range(3, 1);
            else if (pick < 2)       n_args = 0;
            else if (pick < 8)       n_args = $urandom_range(3, 1);
            else if (pick == 8)      n_args = $urandom_range(8, 4);
            else                     n_args = $urandom_range(ARG_MAX, 9);
            with_text = (sc == SC_LONG_TEXT) || (sc == SC_TWO_TEXTS) || (sc == SC_BAD_TEXT) ||
                        ($urandom_range(2) == 0);
            if (sc == SC_LONG_TEXT)          n_chars = TEXT_MAX + 1;
            else if ($urandom_range(9) == 0) n_chars = $urandom_range(TEXT_MAX);
            else                             n_chars = $urandom_range(6);
            if (n_args == 0 && !with_text) begin
                push_byte(CH_NUL, 1'b0);
                if ($urandom_range(2) == 0) push_byte(CH_NUL, 1'b0);
            end else begin
                push_byte(CH_OPEN, 1'b0);
                text_at    = $urandom_range(n_args);
                bad_at     = (sc == SC_RANGE) ? int'($urandom_range(n_args - 1)) : -1;
                first_elem = 1'b1;
                for (int i = 0; i <= n_args; i++) begin
                    if (with_text && i == text_at) begin
                        if (!first_elem) push_byte(CH_COMMA, 1'b0);
                        first_elem = 1'b0;
                        push_text(n_chars, sc == SC_BAD_TEXT);
                        if (sc == SC_TWO_TEXTS) begin
                            push_byte(CH_COMMA, 1'b0);
                            push_text($urandom_range(4), 1'b0);
                        end
                    end
                    if (i < n_args) begin
                        if (!first_elem) push_byte(CH_COMMA, 1'b0);
                        first_elem = 1'b0;
                        if (i == bad_at) begin
                            v = $urandom_range(99999, 32768);
                            if ($urandom_range(1) == 1) v = -v - 1;
                        end else begin
                            case ($urandom_range(9))
                                0:          v = 32767;
                                1:          v = -32768;
                                2:          v = 0;
                                3, 4, 5, 6: v = ($urandom_range(1) == 1) ?
                                                -int'($urandom_range(99)) :
                                                int'($urandom_range(99));
                                default:    v = int'($urandom_range(65535)) - 32768;
                            endcase
                        end
                        push_value(v);
                    end
                end
                push_byte(CH_CLOSE, 1'b0);
                push_byte(CH_NUL, 1'b0);
            end
        end
        if (sc == SC_MUTATED) begin
            pick   = $urandom_range(msg_q.size() - 1);
            b      = msg_q[pick];
            b.ch   = 8'($urandom_range(255));
            msg_q[pick] = b;
        end
    endfunction

    // Offers one byte, idling first as the current phase asks, and returns at the
    // edge where the request is taken.
    task automatic drive_byte(input logic [7:0] c, input logic som, input logic chk,
                              input logic dn, input t_err er);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= som;
        row_chk       <= chk;
        row_done      <= dn;
        row_err       <= er;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // The sender holds off until every queued result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (want_q.size() != 0);
    endtask

    initial begin : stimulus
        int        target;
        int        msg_no;
        int        r;
        t_scenario sc;
        logic      som;
        clear_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PLAN[i])
            drive_byte(PLAN[i].ch, PLAN[i].som, PLAN[i].chk, PLAN[i].done, PLAN[i].err);
        wait_for_results();

        msg_no = 0;
        for (int p = 0; p < 3; p++) begin
            src_idle = SRC_IDLE[p];
            dst_idle = DST_IDLE[p];
            target   = bytes_in + PHASE_BYTES;
            while (bytes_in < target) begin
                // Every kind of message shows up once before the mix turns random.
                if (msg_no <= int'(SC_BAD_OPCODE)) begin
                    sc = t_scenario'(msg_no);
                end else begin
                    r = $urandom_range(99);
                    if (r < 50)      sc = SC_GOOD;
                    else if (r < 58) sc = SC_RANGE;
                    else if (r < 62) sc = SC_MANY_ARGS;
                    else if (r < 66) sc = SC_LONG_TEXT;
                    else if (r < 71) sc = SC_TWO_TEXTS;
                    else if (r < 77) sc = SC_BAD_TEXT;
                    else if (r < 87) sc = SC_MUTATED;
                    else if (r < 94) sc = SC_NOISE;
                    else             sc = SC_BAD_OPCODE;
                end
                // Some good requests follow on without a start flag and append.
                som = !(sc == SC_GOOD && $urandom_range(3) == 0);
                build_message(sc, som);
                foreach (msg_q[i]) drive_byte(msg_q[i].ch, msg_q[i].som, 1'b0, 1'b0, ERR_NONE);
                msg_no++;
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d bytes (%0d parsed) in %0d messages, %0d results, %0d requests.",
                 bytes_in, live_bytes, msg_no, results_seen, requests_done);
        $display("Error codes raised, one bit per code: %b", codes_hit);
        if (mismatches == 0 && want_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/cmp_pkg.sv
rtl/cmp_datapath.sv
rtl/cmp_ctrl.sv
rtl/command_message_parser.sv
verif/command_message_parser_tb.sv
